### src/scl_pkg.sv
// ----------------------------------------------------------------------------
// scl_pkg
// Shared types, codes and character classes for the script character lexer.
// ----------------------------------------------------------------------------
package scl_pkg;

    // Machine mode and lexeme type codes
    localparam logic [3:0] M_NONE  = 4'd0;
    localparam logic [3:0] M_PASS  = 4'd1;
    localparam logic [3:0] M_ERROR = 4'd2;
    localparam logic [3:0] M_NUM   = 4'd3;
    localparam logic [3:0] M_KEY   = 4'd4;
    localparam logic [3:0] M_LABEL = 4'd5;
    localparam logic [3:0] M_FUNC  = 4'd6;
    localparam logic [3:0] M_VAR   = 4'd7;
    localparam logic [3:0] M_STR   = 4'd8;
    localparam logic [3:0] M_EQU   = 4'd9;
    localparam logic [3:0] M_ARITH = 4'd10;
    localparam logic [3:0] M_BRACK = 4'd11;
    localparam logic [3:0] M_DELIM = 4'd12;

    // Event kinds
    localparam logic [1:0] KIND_APPEND = 2'd0;
    localparam logic [1:0] KIND_DONE   = 2'd1;
    localparam logic [1:0] KIND_STATUS = 2'd2;

    // Step queue depth
    localparam int QUEUE_DEPTH = 2;
    localparam int EVENTS_MAX  = 4;

    // Character codes
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_NL     = 8'h0A;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_BANG   = 8'h21;
    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_DOLLAR = 8'h24;
    localparam logic [7:0] CH_PCT    = 8'h25;
    localparam logic [7:0] CH_AMP    = 8'h26;
    localparam logic [7:0] CH_LPAR   = 8'h28;
    localparam logic [7:0] CH_RPAR   = 8'h29;
    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_PLUS   = 8'h2B;
    localparam logic [7:0] CH_COMMA  = 8'h2C;
    localparam logic [7:0] CH_MINUS  = 8'h2D;
    localparam logic [7:0] CH_SLASH  = 8'h2F;
    localparam logic [7:0] CH_0      = 8'h30;
    localparam logic [7:0] CH_9      = 8'h39;
    localparam logic [7:0] CH_COLON  = 8'h3A;
    localparam logic [7:0] CH_SEMI   = 8'h3B;
    localparam logic [7:0] CH_LT     = 8'h3C;
    localparam logic [7:0] CH_EQ     = 8'h3D;
    localparam logic [7:0] CH_GT     = 8'h3E;
    localparam logic [7:0] CH_QMARK  = 8'h3F;
    localparam logic [7:0] CH_AT     = 8'h40;
    localparam logic [7:0] CH_UA     = 8'h41;
    localparam logic [7:0] CH_UZ     = 8'h5A;
    localparam logic [7:0] CH_LSQ    = 8'h5B;
    localparam logic [7:0] CH_RSQ    = 8'h5D;
    localparam logic [7:0] CH_USCORE = 8'h5F;
    localparam logic [7:0] CH_LA     = 8'h61;
    localparam logic [7:0] CH_LZ     = 8'h7A;
    localparam logic [7:0] CH_LBR    = 8'h7B;
    localparam logic [7:0] CH_BAR    = 8'h7C;
    localparam logic [7:0] CH_RBR    = 8'h7D;

    // One result event
    typedef struct packed {
        logic [1:0]  kind;
        logic [7:0]  chr;
        logic [3:0]  ltype;
        logic [6:0]  len;
        logic [15:0] line;
        logic [15:0] col;
        logic [3:0]  mode;
        logic        last;
    } scl_event_t;

    // All events caused by one character, status last
    typedef struct packed {
        scl_event_t [EVENTS_MAX-1:0] ev;
        logic [1:0]                  last_idx;
    } scl_step_t;

    function automatic logic is_blank(input logic [7:0] c);
        return (c == CH_SPACE) || (c == CH_TAB) || (c == CH_NL);
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return (c >= CH_0) && (c <= CH_9);
    endfunction

    function automatic logic is_word_char(input logic [7:0] c);
        return ((c >= CH_LA) && (c <= CH_LZ)) || ((c >= CH_UA) && (c <= CH_UZ)) ||
               (c == CH_USCORE) || (c == CH_MINUS);
    endfunction

    function automatic logic is_ident(input logic [7:0] c);
        return (c == CH_DOLLAR) || (c == CH_QMARK) || (c == CH_AT);
    endfunction

    function automatic logic is_brack(input logic [7:0] c);
        return c inside {CH_LPAR, CH_RPAR, CH_LSQ, CH_RSQ, CH_LBR, CH_RBR};
    endfunction

    function automatic logic is_arith(input logic [7:0] c);
        return c inside {CH_PLUS, CH_MINUS, CH_STAR, CH_SLASH, CH_PCT, CH_GT,
                         CH_LT, CH_EQ, CH_BANG, CH_BAR, CH_AMP};
    endfunction

    function automatic logic is_delim(input logic [7:0] c);
        return (c == CH_SEMI) || (c == CH_COMMA);
    endfunction

    // Class of a character that opens a lexeme
    function automatic logic [3:0] classify(input logic [7:0] c);
        logic [3:0] m;
        if (is_blank(c))          m = M_PASS;
        else if (is_digit(c))     m = M_NUM;
        else if (is_word_char(c)) m = M_KEY;
        else if (c == CH_DOLLAR)  m = M_VAR;
        else if (c == CH_QMARK)   m = M_FUNC;
        else if (c == CH_AT)      m = M_LABEL;
        else if (c == CH_QUOTE)   m = M_STR;
        else if (c == CH_COLON)   m = M_EQU;
        else if (is_arith(c))     m = M_ARITH;
        else if (is_delim(c))     m = M_DELIM;
        else if (is_brack(c))     m = M_BRACK;
        else                      m = M_ERROR;
        return m;
    endfunction

    function automatic scl_event_t mk_event(
        input logic [1:0]  kind,
        input logic [7:0]  chr,
        input logic [3:0]  ltype,
        input logic [6:0]  len,
        input logic [15:0] line,
        input logic [15:0] col,
        input logic [3:0]  mode,
        input logic        last
    );
        scl_event_t e;
        e.kind  = kind;
        e.chr   = chr;
        e.ltype = ltype;
        e.len   = len;
        e.line  = line;
        e.col   = col;
        e.mode  = mode;
        e.last  = last;
        return e;
    endfunction

endpackage

### src/scl_front.sv
// ----------------------------------------------------------------------------
// scl_front
// Accepts one character a cycle while take is high, classifies it, updates the
// lexer state and builds the full list of events that the character causes.
// ----------------------------------------------------------------------------
module scl_front
    import scl_pkg::*;
#(
    parameter int MAX_LEXEME_LEN = 127,
    parameter int COUNTER_WIDTH  = 16
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      take,
    input  logic [7:0] ch,
    output scl_step_t rec
);

    localparam int LW = $clog2(MAX_LEXEME_LEN + 1);
    localparam logic [LW-1:0]            LEN_MAX = LW'(MAX_LEXEME_LEN);
    localparam logic [LW-1:0]            LEN_ONE = LW'(1);
    localparam logic [COUNTER_WIDTH-1:0] CNT_ONE = COUNTER_WIDTH'(1);
    localparam logic [COUNTER_WIDTH-1:0] CNT_TOP = {COUNTER_WIDTH{1'b1}};

    logic [3:0]               mode_reg,  mode_next;
    logic                     quote_reg, quote_next;
    logic [LW-1:0]            count_reg, count_next;
    logic [COUNTER_WIDTH-1:0] line_reg,  line_next;
    logic [COUNTER_WIDTH-1:0] col_reg,   col_next;

    // Lexer step
    always_comb
    begin
        logic [3:0]               m;
        logic [3:0]               cls;
        logic                     q;
        logic [LW-1:0]            cnt;
        logic [COUNTER_WIDTH-1:0] lc;
        logic [COUNTER_WIDTH-1:0] cc;
        logic [1:0]               n;
        logic                     do_app;
        logic                     app_done;
        logic                     do_term;
        logic                     do_quote;
        logic                     do_err;
        logic                     is_term;

        m        = mode_reg;
        q        = quote_reg;
        cnt      = count_reg;
        lc       = line_reg;
        cc       = col_reg;
        n        = 2'd0;
        rec      = '0;
        cls      = classify(ch);
        do_app   = 1'b0;
        app_done = 1'b0;
        do_term  = 1'b0;
        do_quote = 1'b0;
        do_err   = 1'b0;
        is_term  = is_delim(ch) || is_blank(ch) || is_arith(ch) || is_brack(ch);

        if ((m == M_NONE) || (m == M_PASS))
        begin
            m = cls;
        end

        // Action decode on the current mode
        unique case (m) inside
            M_PASS, M_ERROR:
            begin
            end
            M_NUM:
            begin
                if (is_digit(ch))  do_app  = 1'b1;
                else if (is_term)  do_term = 1'b1;
                else               do_err  = 1'b1;
            end
            M_KEY:
            begin
                if (is_word_char(ch)) do_app  = 1'b1;
                else if (is_term)     do_term = 1'b1;
                else                  do_err  = 1'b1;
            end
            M_STR:
            begin
                if (is_word_char(ch) || is_digit(ch)) do_app   = 1'b1;
                else if (ch == CH_QUOTE)              do_quote = 1'b1;
                else                                  do_err   = 1'b1;
            end
            M_ARITH, M_BRACK, M_DELIM:
            begin
                do_app   = 1'b1;
                app_done = 1'b1;
            end
            M_EQU:
            begin
                if (ch == CH_COLON)
                begin
                    do_app = 1'b1;
                end
                else if (ch == CH_EQ)
                begin
                    do_app   = 1'b1;
                    app_done = 1'b1;
                end
                else
                begin
                    do_err = 1'b1;
                end
            end
            M_VAR, M_FUNC, M_LABEL:
            begin
                if (is_word_char(ch) || is_digit(ch)) do_app  = 1'b1;
                else if (is_term)                     do_term = 1'b1;
                else if (!is_ident(ch))               do_err  = 1'b1;
            end
            default:
            begin
                do_err = 1'b1;
            end
        endcase

        // Append, possibly followed by completion
        if (do_app)
        begin
            if (cnt >= LEN_MAX)
            begin
                m = M_ERROR;
            end
            else
            begin
                cnt = cnt + LEN_ONE;
                if (cc != CNT_TOP) cc = cc + CNT_ONE;
                rec.ev[n] = mk_event(KIND_APPEND, ch, M_NONE, 7'd0, 16'(lc), 16'(cc), m,
                                     1'b0);
                n = n + 2'd1;
                if (app_done)
                begin
                    rec.ev[n] = mk_event(KIND_DONE, 8'd0, m, 7'(cnt), 16'(lc), 16'(cc),
                                         M_NONE, 1'b0);
                    n   = n + 2'd1;
                    m   = M_NONE;
                    cnt = '0;
                end
            end
        end

        // Terminator: close the lexeme, punctuation becomes its own token
        if (do_term)
        begin
            rec.ev[n] = mk_event(KIND_DONE, 8'd0, m, 7'(cnt), 16'(lc), 16'(cc), M_NONE, 1'b0);
            n   = n + 2'd1;
            m   = M_NONE;
            cnt = '0;
            if (!is_blank(ch))
            begin
                if (cc != CNT_TOP) cc = cc + CNT_ONE;
                rec.ev[n] = mk_event(KIND_APPEND, ch, M_NONE, 7'd0, 16'(lc), 16'(cc),
                                     M_NONE, 1'b0);
                n = n + 2'd1;
                rec.ev[n] = mk_event(KIND_DONE, 8'd0, cls, 7'(LEN_ONE), 16'(lc), 16'(cc),
                                     M_NONE, 1'b0);
                n = n + 2'd1;
            end
        end

        // Quote mark toggles; closing quote completes the string
        if (do_quote)
        begin
            q = ~q;
            if (!q)
            begin
                rec.ev[n] = mk_event(KIND_DONE, 8'd0, M_STR, 7'(cnt), 16'(lc), 16'(cc),
                                     M_NONE, 1'b0);
                n   = n + 2'd1;
                m   = M_NONE;
                cnt = '0;
            end
        end

        if (do_err)
        begin
            m = M_ERROR;
        end

        // Newline bumps the line and clears the column and any error
        if (ch == CH_NL)
        begin
            if (lc != CNT_TOP) lc = lc + CNT_ONE;
            cc = '0;
            m  = M_NONE;
        end

        rec.ev[n]    = mk_event(KIND_STATUS, 8'd0, M_NONE, 7'd0, 16'(lc), 16'(cc), m, 1'b1);
        rec.last_idx = n;

        mode_next  = m;
        quote_next = q;
        count_next = cnt;
        line_next  = lc;
        col_next   = cc;
    end

    // State registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg  <= M_NONE;
            quote_reg <= 1'b0;
            count_reg <= '0;
            line_reg  <= CNT_ONE;
            col_reg   <= CNT_ONE;
        end
        else if (take)
        begin
            mode_reg  <= mode_next;
            quote_reg <= quote_next;
            count_reg <= count_next;
            line_reg  <= line_next;
            col_reg   <= col_next;
        end
    end

endmodule

### src/scl_queue.sv
// ----------------------------------------------------------------------------
// scl_queue
// Short queue of step records between the front and the back.
// ----------------------------------------------------------------------------
module scl_queue
    import scl_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      push,
    input  scl_step_t push_data,
    output logic      full,
    input  logic      pop,
    output scl_step_t head,
    output logic      empty
);

    localparam int PW = $clog2(QUEUE_DEPTH);
    localparam int FW = $clog2(QUEUE_DEPTH + 1);
    localparam logic [FW-1:0] FILL_FULL = FW'(QUEUE_DEPTH);
    localparam logic [FW-1:0] FILL_ONE  = FW'(1);
    localparam logic [PW-1:0] PTR_ONE   = PW'(1);

    scl_step_t       entry_reg [QUEUE_DEPTH];
    logic [PW-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [FW-1:0]   fill_reg,   fill_next;

    assign full  = (fill_reg == FILL_FULL);
    assign empty = (fill_reg == '0);
    assign head  = entry_reg[rd_ptr_reg];

    // Pointer and fill update
    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + PTR_ONE : wr_ptr_reg;
        rd_ptr_next = pop  ? rd_ptr_reg + PTR_ONE : rd_ptr_reg;
        fill_next   = fill_reg;
        if (push && !pop)      fill_next = fill_reg + FILL_ONE;
        else if (pop && !push) fill_next = fill_reg - FILL_ONE;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    // Payload storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

### src/scl_back.sv
// ----------------------------------------------------------------------------
// scl_back
// Walks the events of the step record at the queue head, one per transaction.
// ----------------------------------------------------------------------------
module scl_back
    import scl_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  scl_step_t  head,
    input  logic       empty,
    output logic       pop,
    output logic       event_valid,
    input  logic       event_ready,
    output scl_event_t cur
);

    logic [1:0] idx_reg, idx_next;
    logic       at_last;

    assign event_valid = !empty;
    assign cur         = head.ev[idx_reg];
    assign at_last     = (idx_reg == head.last_idx);
    assign pop         = event_valid && event_ready && at_last;

    // Event index within the current record
    always_comb
    begin
        idx_next = idx_reg;
        if (event_valid && event_ready)
        begin
            idx_next = at_last ? 2'd0 : idx_reg + 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg <= 2'd0;
        end
        else
        begin
            idx_reg <= idx_next;
        end
    end

endmodule

### src/script_char_lexer_core.sv
// An accepted character is registered into the step queue as a step record.
// Throughput: the front takes one character a cycle while the two-entry step
// queue has room; the back delivers one event a cycle while event_ready is
// high, and a character causes 1 to 4 events (status included).
// Reset: rst_n clears the queue and the lexer state asynchronously; line and
// column restart at 1 and the mode at none.
// ----------------------------------------------------------------------------
// script_char_lexer_core
// Character-at-a-time script lexer: front classifier, step queue, event back.
// ----------------------------------------------------------------------------
module script_char_lexer_core
    import scl_pkg::*;
#(
    parameter int MAX_LEXEME_LEN = 127,
    parameter int COUNTER_WIDTH  = 16
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        ch_valid,
    output logic        ch_ready,
    input  logic [7:0]  ch,
    output logic        event_valid,
    input  logic        event_ready,
    output logic [1:0]  event_kind,
    output logic [7:0]  token_char,
    output logic [3:0]  lexeme_type,
    output logic [6:0]  lexeme_length,
    output logic [15:0] line_index,
    output logic [15:0] column_count,
    output logic [3:0]  machine_mode,
    output logic        last_of_run
);

    scl_step_t  rec;
    scl_step_t  head;
    scl_event_t cur;
    logic       full;
    logic       empty;
    logic       take;
    logic       pop;

    assign ch_ready = !full;
    assign take     = ch_valid && ch_ready;

    // Front: classify and step the lexer
    scl_front #(
        .MAX_LEXEME_LEN (MAX_LEXEME_LEN),
        .COUNTER_WIDTH  (COUNTER_WIDTH)
    ) u_front (
        .clk   (clk),
        .rst_n (rst_n),
        .take  (take),
        .ch    (ch),
        .rec   (rec)
    );

    // Step queue
    scl_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (take),
        .push_data (rec),
        .full      (full),
        .pop       (pop),
        .head      (head),
        .empty     (empty)
    );

    // Back: event sequencer
    scl_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .head        (head),
        .empty       (empty),
        .pop         (pop),
        .event_valid (event_valid),
        .event_ready (event_ready),
        .cur         (cur)
    );

    assign event_kind    = cur.kind;
    assign token_char    = cur.chr;
    assign lexeme_type   = cur.ltype;
    assign lexeme_length = cur.len;
    assign line_index    = cur.line;
    assign column_count  = cur.col;
    assign machine_mode  = cur.mode;
    assign last_of_run   = cur.last;

`ifndef SYNTHESIS
    // Only the status event closes a character's run
    assert property (@(posedge clk) disable iff (!rst_n)
        event_valid && last_of_run |-> event_kind == KIND_STATUS)
        else $error("last_of_run on a non-status event");

    // A transaction into an empty pipe yields an event next cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        ch_valid && ch_ready && !event_valid |=> event_valid)
        else $error("accepted character produced no event");

    // Events of one character follow without a gap
    assert property (@(posedge clk) disable iff (!rst_n)
        event_valid && event_ready && !last_of_run |=> event_valid)
        else $error("event run broken before its status");
`endif

endmodule
